[rtl/core/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, widths and codes for the circular deque block.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// ring geometry
	localparam int DEPTH  = 16;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// request and result field widths
	localparam int REQ_W  = 3;
	localparam int IDX_W  = 4;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int CAP_W  = 5;

	// configuration port
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	typedef logic [PTR_W-1:0]         ptr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [REQ_W-1:0]         req_code_t;
	typedef logic [STAT_W-1:0]        status_t;
	typedef logic [CAP_W-1:0]         cap_t;

	// request codes
	localparam req_code_t REQ_PUSH_FRONT = 3'd0;
	localparam req_code_t REQ_PUSH_BACK  = 3'd1;
	localparam req_code_t REQ_POP_FRONT  = 3'd2;
	localparam req_code_t REQ_POP_BACK   = 3'd3;
	localparam req_code_t REQ_PEEK       = 3'd4;

	// status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_BOUNDS    = 2'd3;

	// register index of the capacity register
	localparam logic REG_CAPACITY = 1'b0;

	localparam cap_t  CAP_RESET = 5'd16;
	localparam word_t ERR_WORD  = -32'sd1;

	// request sequencer states
	typedef enum logic {
		S_IDLE,
		S_READ
	} cdq_state_t;

	// ring memory access for one cycle
	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		word_t wdata;
		logic  re;
		ptr_t  raddr;
	} cdq_ram_req_t;

endpackage

[rtl/core/cdq_if.sv]
// ----------------------------------------------------------------------------
// cdq_req_if / cdq_rsp_if
// Valid/ready channels for deque requests and results.
// ----------------------------------------------------------------------------
interface cdq_req_if;
	import cdq_pkg::*;

	logic      valid;
	logic      ready;
	req_code_t req_type;
	word_t     value;
	logic [IDX_W-1:0] index;

	modport source (output valid, output req_type, output value, output index, input ready);
	modport sink   (input valid, input req_type, input value, input index, output ready);
endinterface

interface cdq_rsp_if;
	import cdq_pkg::*;

	logic    valid;
	logic    ready;
	word_t   data;
	status_t status;
	cnt_t    count;
	logic    is_full_flag;
	logic    is_empty_flag;

	modport source (
		output valid, output data, output status, output count,
		output is_full_flag, output is_empty_flag, input ready
	);
	modport sink (
		input valid, input data, input status, input count,
		input is_full_flag, input is_empty_flag, output ready
	);
endinterface

[rtl/core/circular_deque.sv]
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a ring store with a programmable capacity.
// ----------------------------------------------------------------------------
//  channel  dir  protocol     payload
//  req      in   valid/ready  req_type, value, index
//  rsp      out  valid/ready  data, status, count, is_full_flag, is_empty_flag
//  apb      in   apb write    capacity at byte address 0
//
//  a push or any failing request is registered straight into rsp; a good pop or peek
//  first reads the ring memory, then registers the word into rsp
//  the registered read port of the ring store adds that read step
//  reset empties the deque and sets capacity to 16; ring contents undefined
//  a new request is taken while a result waits, as long as rsp drains
//  a capacity write empties the deque
// ----------------------------------------------------------------------------
module circular_deque (
	input  logic                       clk,
	input  logic                       arst_n,
	cdq_req_if.sink                    req,
	cdq_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cdq_pkg::APB_AW-1:0] paddr,
	input  logic [cdq_pkg::APB_DW-1:0] pwdata,
	output logic [cdq_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import cdq_pkg::*;

	// ring pointer helpers
	function automatic ptr_t ring_inc(ptr_t p, cnt_t cap);
		cnt_t s;
		s = cnt_t'(p) + cnt_t'(1);
		return (s >= cap) ? ptr_t'(s - cap) : ptr_t'(s);
	endfunction

	function automatic ptr_t ring_dec(ptr_t p, cnt_t cap);
		return (p == '0) ? ptr_t'(cap - cnt_t'(1)) : ptr_t'(p - ptr_t'(1));
	endfunction

	cdq_state_t   state_q, state_nxt;
	ptr_t         head_q, tail_q;
	cnt_t         count_q;
	cap_t         cap_q;
	cnt_t         cap_eff;

	ptr_t         nxt_head, nxt_tail;
	cnt_t         nxt_count;
	status_t      res_status;
	word_t        res_data;
	logic         needs_read;
	logic         we_c, re_c;
	ptr_t         waddr_c, raddr_c;
	cnt_t         peek_sum;
	cdq_ram_req_t ram_req;
	word_t        ram_rdata;

	logic         out_free, in_acc, cfg_wr, rd_done;

	logic         out_valid_q;
	word_t        out_data_q;
	status_t      out_status_q;
	cnt_t         out_count_q;
	logic         out_full_q, out_empty_q;

	cnt_t         pend_count_q;
	logic         pend_full_q, pend_empty_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[APB_AW-1:2] == REG_CAPACITY);
	assign prdata = (paddr[APB_AW-1:2] == REG_CAPACITY) ?
		{{(APB_DW-CAP_W){1'b0}}, cap_q} : '0;

	// capacity in force, clamped to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = cnt_t'(1);
		end else if (int'(cap_q) > DEPTH) begin
			cap_eff = cnt_t'(DEPTH);
		end else begin
			cap_eff = cnt_t'(cap_q);
		end
	end

	assign peek_sum = cnt_t'(head_q) + cnt_t'(req.index);

	// request decode, pointer update and ring access
	always_comb begin
		nxt_head   = head_q;
		nxt_tail   = tail_q;
		nxt_count  = count_q;
		res_status = ST_OK;
		res_data   = '0;
		needs_read = 1'b0;
		we_c       = 1'b0;
		re_c       = 1'b0;
		waddr_c    = '0;
		raddr_c    = head_q;
		unique case (req.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (count_q >= cap_eff) begin
					res_status = ST_OVERFLOW;
					res_data   = ERR_WORD;
				end else begin
					we_c      = 1'b1;
					nxt_count = count_q + cnt_t'(1);
					if (count_q == '0) begin
						nxt_head = '0;
						nxt_tail = '0;
						waddr_c  = '0;
					end else if (req.req_type == REQ_PUSH_FRONT) begin
						nxt_head = ring_dec(head_q, cap_eff);
						waddr_c  = nxt_head;
					end else begin
						nxt_tail = ring_inc(tail_q, cap_eff);
						waddr_c  = nxt_tail;
					end
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (count_q == '0) begin
					res_status = ST_UNDERFLOW;
					res_data   = ERR_WORD;
				end else begin
					re_c       = 1'b1;
					needs_read = 1'b1;
					raddr_c    = (req.req_type == REQ_POP_FRONT) ? head_q : tail_q;
					nxt_count  = count_q - cnt_t'(1);
					if (count_q == cnt_t'(1)) begin
						nxt_head = '0;
						nxt_tail = '0;
					end else if (req.req_type == REQ_POP_FRONT) begin
						nxt_head = ring_inc(head_q, cap_eff);
					end else begin
						nxt_tail = ring_dec(tail_q, cap_eff);
					end
				end
			end
			REQ_PEEK: begin
				if (count_q == '0) begin
					res_status = ST_UNDERFLOW;
					res_data   = ERR_WORD;
				end else if (req.index >= count_q) begin
					res_status = ST_BOUNDS;
					res_data   = ERR_WORD;
				end else begin
					re_c       = 1'b1;
					needs_read = 1'b1;
					raddr_c    = (peek_sum >= cap_eff) ? ptr_t'(peek_sum - cap_eff)
						: ptr_t'(peek_sum);
				end
			end
			default: begin
			end
		endcase
	end

	// ring memory access, only on an accepted transaction
	always_comb begin
		ram_req.we    = we_c & in_acc;
		ram_req.waddr = waddr_c;
		ram_req.wdata = req.value;
		ram_req.re    = re_c & in_acc;
		ram_req.raddr = raddr_c;
	end

	cdq_ring_ram u_ring (
		.clk     (clk),
		.ram_req (ram_req),
		.rdata   (ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && needs_read) begin
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		out_free  = !out_valid_q || rsp.ready;
		req.ready = (state_q == S_IDLE) && out_free;
		in_acc    = req.valid && req.ready;
		rd_done   = (state_q == S_READ) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// deque pointers, count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else if (cfg_wr) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cap_q   <= pwdata[CAP_W-1:0];
		end else if (in_acc) begin
			head_q  <= nxt_head;
			tail_q  <= nxt_tail;
			count_q <= nxt_count;
		end
	end

	// result fields held while the ring read completes
	always_ff @(posedge clk) begin
		if (in_acc && needs_read) begin
			pend_count_q <= nxt_count;
			pend_full_q  <= (nxt_count == cap_eff);
			pend_empty_q <= (nxt_count == '0);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && !needs_read) || rd_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (rd_done) begin
			out_data_q   <= ram_rdata;
			out_status_q <= ST_OK;
			out_count_q  <= pend_count_q;
			out_full_q   <= pend_full_q;
			out_empty_q  <= pend_empty_q;
		end else if (in_acc && !needs_read) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
			out_count_q  <= nxt_count;
			out_full_q   <= (nxt_count == cap_eff);
			out_empty_q  <= (nxt_count == '0);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.data          = out_data_q;
	assign rsp.status        = out_status_q;
	assign rsp.count         = out_count_q;
	assign rsp.is_full_flag  = out_full_q;
	assign rsp.is_empty_flag = out_empty_q;

`ifndef NO_ASSERTIONS
	// the deque never holds more than the capacity in force
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff)
		else $error("entry count above capacity");

	// pointers stay inside the ring in use
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_t'(head_q) < cap_eff) && (cnt_t'(tail_q) < cap_eff))
		else $error("ring pointer outside capacity");

	// a finished read always lands in the output register
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_done |=> out_valid_q && (state_q == S_IDLE))
		else $error("ring read lost");

	// no new transaction while a ring read is in flight
	a_no_accept_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !req.ready)
		else $error("request taken during ring read");
`endif
endmodule

[rtl/core/cdq_ring_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ring_ram
// Single-port-write, single-port-read ring store with registered read data.
// ----------------------------------------------------------------------------
module cdq_ring_ram (
	input  logic                 clk,
	input  cdq_pkg::cdq_ram_req_t ram_req,
	output cdq_pkg::word_t       rdata
);
	import cdq_pkg::*;

	word_t mem [DEPTH];
	word_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			mem[ram_req.waddr] <= ram_req.wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (ram_req.re) begin
			rdata_q <= mem[ram_req.raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circular_deque. A directed table covers the empty,
// full, out-of-range peek and unused-code cases, then random push, pop and
// peek traffic runs under several capacity settings. Both channels see random
// gaps, and each result is checked against its table row or an in-bench deque model.
// ----------------------------------------------------------------------------
module testbench;
	import cdq_pkg::*;

	// unused request codes, which must leave the deque alone
	localparam req_code_t REQ_UNUSED_FIRST = 3'd5;
	localparam req_code_t REQ_UNUSED_LAST  = 3'd7;

	localparam logic [APB_AW-1:0] CAPACITY_ADDR = APB_AW'(4 * int'(REG_CAPACITY));

	localparam int DIRECTED_ROWS   = 24;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 94;
	localparam int SEGMENT_LEN     = 16;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		word_t   data;
		status_t status;
		cnt_t    count;
		logic    full;
		logic    empty;
	} deque_result_t;

	// one line of the directed table: either a capacity write or a request
	typedef struct packed {
		logic             cfg;
		cap_t             cap;
		req_code_t        op;
		word_t            val;
		logic [IDX_W-1:0] idx;
		logic             typed;
		deque_result_t    res;
	} directed_row_t;

	localparam deque_result_t NO_CHECK = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	circular_deque dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// directed table: typed expectations only where obvious
	directed_row_t directed_plan [DIRECTED_ROWS] = '{
		'{1'b0, CAP_RESET, REQ_POP_FRONT, 32'sd0, 4'd0, 1'b1,
			'{ERR_WORD, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
		'{1'b0, CAP_RESET, REQ_POP_BACK, 32'sd0, 4'd0, 1'b1,
			'{ERR_WORD, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
		'{1'b0, CAP_RESET, REQ_PEEK, 32'sd0, 4'd0, 1'b1,
			'{ERR_WORD, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
		'{1'b0, CAP_RESET, REQ_PUSH_BACK, 32'sh7fffffff, 4'd0, 1'b1,
			'{32'sd0, ST_OK, 5'd1, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_PUSH_FRONT, 32'sh80000000, 4'd0, 1'b1,
			'{32'sd0, ST_OK, 5'd2, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_PUSH_BACK, -32'sd1, 4'd0, 1'b1,
			'{32'sd0, ST_OK, 5'd3, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_PEEK, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b0, CAP_RESET, REQ_PEEK, 32'sd0, 4'd2, 1'b0, NO_CHECK},
		'{1'b0, CAP_RESET, REQ_PEEK, 32'sd0, 4'd3, 1'b1,
			'{ERR_WORD, ST_BOUNDS, 5'd3, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_PEEK, 32'sd0, 4'd15, 1'b1,
			'{ERR_WORD, ST_BOUNDS, 5'd3, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_UNUSED_FIRST, 32'sh5555aaaa, 4'd9, 1'b1,
			'{32'sd0, ST_OK, 5'd3, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_UNUSED_LAST, -32'sd1, 4'd15, 1'b1,
			'{32'sd0, ST_OK, 5'd3, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_POP_BACK, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b0, CAP_RESET, REQ_POP_FRONT, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b0, CAP_RESET, REQ_POP_FRONT, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b0, CAP_RESET, REQ_PUSH_FRONT, 32'sh12345678, 4'd0, 1'b1,
			'{32'sd0, ST_OK, 5'd1, 1'b0, 1'b0}},
		'{1'b0, CAP_RESET, REQ_PEEK, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b1, 5'd1, REQ_PUSH_FRONT, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b0, CAP_RESET, REQ_PUSH_BACK, 32'sd0, 4'd0, 1'b1,
			'{32'sd0, ST_OK, 5'd1, 1'b1, 1'b0}},
		'{1'b0, CAP_RESET, REQ_PUSH_FRONT, 32'sh5a5a5a5a, 4'd0, 1'b1,
			'{ERR_WORD, ST_OVERFLOW, 5'd1, 1'b1, 1'b0}},
		'{1'b0, CAP_RESET, REQ_PEEK, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b1, CAP_RESET, REQ_PUSH_FRONT, 32'sd0, 4'd0, 1'b0, NO_CHECK},
		'{1'b0, CAP_RESET, REQ_POP_FRONT, 32'sd0, 4'd0, 1'b1,
			'{ERR_WORD, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
		'{1'b0, CAP_RESET, REQ_PUSH_BACK, 32'sh0f0f0f0f, 4'd0, 1'b1,
			'{32'sd0, ST_OK, 5'd1, 1'b0, 1'b0}}
	};

	// capacity per random phase; two entries get randomized at start
	cap_t phase_caps [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd9, 5'd17, 5'd1, 5'd12};

	// deque model state
	word_t ring_copy [DEPTH];
	ptr_t  head_pos;
	ptr_t  tail_pos;
	cnt_t  held;
	cap_t  cap_setting;

	deque_result_t awaited_results [$];

	int  errors;
	int  items_sent;
	int  directed_sent;
	int  results_checked;
	int  caps_written;
	int  hold_offs_done;
	int  status_seen [4];
	bit  calm_stretch;
	bit  hold_off_request;

	// capacity in effect: 0 acts as 1, anything above DEPTH acts as DEPTH
	function automatic int active_cap();
		if (cap_setting == 0) return 1;
		if (int'(cap_setting) > DEPTH) return DEPTH;
		return int'(cap_setting);
	endfunction

	function automatic ptr_t ring_fwd(ptr_t pos, int n, int cap);
		int s;
		s = int'(pos) % cap + n % cap;
		if (s >= cap) s = s - cap;
		return ptr_t'(s);
	endfunction

	function automatic ptr_t ring_back(ptr_t pos, int cap);
		int p;
		p = int'(pos) % cap;
		return ptr_t'((p == 0) ? cap - 1 : p - 1);
	endfunction

	// apply one request to the model deque and return its result
	function automatic deque_result_t apply_request(req_code_t op, word_t val,
			logic [IDX_W-1:0] idx);
		deque_result_t r;
		int cap;
		cap = active_cap();
		r = '0;
		r.status = ST_OK;
		case (op)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (int'(held) >= cap) begin
					r.status = ST_OVERFLOW;
					r.data = ERR_WORD;
				end else begin
					if (held == 0) begin
						head_pos = '0;
						tail_pos = '0;
						ring_copy[0] = val;
					end else if (op == REQ_PUSH_FRONT) begin
						head_pos = ring_back(head_pos, cap);
						ring_copy[head_pos] = val;
					end else begin
						tail_pos = ring_fwd(tail_pos, 1, cap);
						ring_copy[tail_pos] = val;
					end
					held = held + 1'b1;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK: begin
				if (held == 0) begin
					r.status = ST_UNDERFLOW;
					r.data = ERR_WORD;
				end else if (op == REQ_POP_FRONT) begin
					r.data = ring_copy[int'(head_pos) % cap];
					held = held - 1'b1;
					if (held == 0) begin
						head_pos = '0;
						tail_pos = '0;
					end else begin
						head_pos = ring_fwd(head_pos, 1, cap);
					end
				end else if (op == REQ_POP_BACK) begin
					r.data = ring_copy[int'(tail_pos) % cap];
					held = held - 1'b1;
					if (held == 0) begin
						head_pos = '0;
						tail_pos = '0;
					end else begin
						tail_pos = ring_back(tail_pos, cap);
					end
				end else if (int'(idx) >= int'(held)) begin
					r.status = ST_BOUNDS;
					r.data = ERR_WORD;
				end else begin
					r.data = ring_copy[ring_fwd(head_pos, int'(idx), cap)];
				end
			end
			default: ;
		endcase
		r.count = held;
		r.full  = (int'(held) == cap);
		r.empty = (held == 0);
		return r;
	endfunction

	// idle length: mostly none or short, a few long, none in calm stretches
	function automatic int idle_gap();
		int r;
		if (calm_stretch) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// offer one request and record its expected result once accepted
	task automatic send_request(req_code_t op, word_t val, logic [IDX_W-1:0] idx,
			bit typed, deque_result_t typed_res);
		deque_result_t want;
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.value    <= val;
		req_ch.index    <= idx;
		do @(posedge clk); while (!req_ch.ready);
		want = apply_request(op, val, idx);
		if (typed) want = typed_res;
		awaited_results.push_back(want);
		items_sent++;
	endtask

	// stop offering and wait until every result is back and the block is quiet
	task automatic settle_deque();
		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity write through the register port, only while idle
	task automatic set_capacity(cap_t cap);
		settle_deque();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= ($urandom & ~32'h1f) | APB_DW'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cap_setting = cap;
		held     = '0;
		head_pos = '0;
		tail_pos = '0;
		caps_written++;
	endtask

	// result side ready: bursts, random gaps, and one long hold-off on request
	initial begin : result_ready
		int burst;
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_request = 1'b0;
				hold_offs_done++;
			end else begin
				rsp_ch.ready <= 1'b1;
				burst = $urandom_range(1, 24);
				repeat (burst) @(posedge clk);
				gap = idle_gap();
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		deque_result_t want;
		deque_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.data, rsp_ch.status, rsp_ch.count,
				rsp_ch.is_full_flag, rsp_ch.is_empty_flag};
			status_seen[got.status]++;
			results_checked++;
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("[%0t] unexpected result: data %h status %0d count %0d %s %b %s %b",
						$realtime, got.data, got.status, got.count, "full", got.full,
						"empty", got.empty);
			end else begin
				want = awaited_results.pop_front();
				if (got.data !== want.data || got.status !== want.status ||
						got.count !== want.count || got.full !== want.full ||
						got.empty !== want.empty) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("[%0t] mismatch: expected data %h status %0d count %0d %s",
							$realtime, want.data, want.status, want.count,
							$sformatf("full %b empty %b", want.full, want.empty));
						$display("[%0t]           got data %h status %0d count %0d %s",
							$realtime, got.data, got.status, got.count,
							$sformatf("full %b empty %b", got.full, got.empty));
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		req_code_t op;
		word_t val;
		logic [IDX_W-1:0] idx;
		int mode;
		int push_pct;
		int pop_pct;
		int r;

		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_PUSH_FRONT;
		req_ch.value    <= '0;
		req_ch.index    <= '0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;

		cap_setting = CAP_RESET;
		held        = '0;
		head_pos    = '0;
		tail_pos    = '0;
		phase_caps[4] = cap_t'($urandom_range(3, 15));
		phase_caps[7] = cap_t'($urandom_range(3, 15));

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_plan[i]) begin
			if (directed_plan[i].cfg) begin
				set_capacity(directed_plan[i].cap);
			end else begin
				send_request(directed_plan[i].op, directed_plan[i].val,
					directed_plan[i].idx, directed_plan[i].typed, directed_plan[i].res);
				directed_sent++;
			end
		end

		// random traffic, one capacity setting per phase
		mode = 2;
		for (int phase = 0; phase < PHASES; phase++) begin
			set_capacity(phase_caps[phase]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// new bias and idling style every segment
				if (n % SEGMENT_LEN == 0) begin
					mode = $urandom_range(0, 2);
					calm_stretch = ($urandom_range(0, 4) == 0);
				end
				// long result stall while requests keep coming
				if (phase == 0 && n == 30) hold_off_request = 1'b1;
				// sender pause until every result is back
				if ((phase == 0 || phase == 3) && n == 70) settle_deque();

				case (mode)
					0: begin push_pct = 62; pop_pct = 15; end
					1: begin push_pct = 15; pop_pct = 62; end
					default: begin push_pct = 35; pop_pct = 35; end
				endcase
				r = $urandom_range(0, 99);
				if (r < 3)
					op = req_code_t'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
				else if (r < 3 + push_pct)
					op = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
				else if (r < 3 + push_pct + pop_pct)
					op = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
				else
					op = REQ_PEEK;

				// word extremes now and then
				case ($urandom_range(0, 15))
					0: val = 32'sh80000000;
					1: val = 32'sh7fffffff;
					2: val = 32'sd0;
					3: val = -32'sd1;
					default: val = word_t'($urandom);
				endcase

				// peek mostly inside the held range
				if (held != 0 && $urandom_range(0, 9) < 8)
					idx = IDX_W'($urandom_range(0, int'(held) - 1));
				else
					idx = IDX_W'($urandom_range(0, 15));

				send_request(op, val, idx, 1'b0, NO_CHECK);
			end
		end

		// drain and let the block settle
		calm_stretch = 1'b0;
		settle_deque();
		repeat (8) @(posedge clk);

		$display("covered %0d requests (%0d directed) over %0d capacity writes",
			items_sent, directed_sent, caps_written);
		$display("%0d results checked; ok %0d, overflow %0d, underflow %0d, %s %0d; %s %0d",
			results_checked, status_seen[ST_OK], status_seen[ST_OVERFLOW],
			status_seen[ST_UNDERFLOW], "out of bounds", status_seen[ST_BOUNDS],
			"long result stalls", hold_offs_done);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/cdq_pkg.sv
rtl/core/cdq_if.sv
rtl/core/cdq_ring_ram.sv
rtl/core/circular_deque.sv
test/testbench.sv
